// ===== sv/spd_pkg.sv =====
`default_nettype none
package spd_pkg;

  localparam int XY_W  = 11;
  localparam int PIX_W = 8;
  localparam int TBL_AW = 16;
  localparam int TBL_DEPTH = 65536;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = 2;

  typedef struct packed {
    logic [XY_W-1:0] width;
    logic [XY_W-1:0] height;
    logic            hv;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_BLEND,
    ST_ODD,
    ST_EVEN,
    ST_COPY
  } seq_state_e;

  // one issued operation of the sequencer
  typedef struct packed {
    logic              vld;    // produces a result
    logic              hb;     // horizontal blend lookup
    logic              wr;     // table write
    logic              odd;    // vertical blend row
    logic              lbw;    // line buffer write
    logic              use_h;  // value is the horizontal blend
    logic              last;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [PIX_W-1:0]  v;
    logic [TBL_AW-1:0] taddr;
  } uop_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
    logic [XY_W-1:0]  y;
    logic [XY_W-1:0]  x;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/spd_seq.sv =====
`default_nettype none
module spd_seq #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  spd_pkg::cfg_t              cfg_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        in_op_i,
  input  wire  [7:0]                 in_pixel_i,
  input  wire  [15:0]                in_tidx_i,
  input  wire  [7:0]                 in_tdata_i,
  input  wire                        credit_ok_i,
  output spd_pkg::uop_t              uop_o,
  output logic [$clog2(MAX_WIDTH):0] lb_addr_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW = ((CW + 1) > spd_pkg::XY_W) ? (CW + 1) : spd_pkg::XY_W;
  localparam int HCW = ((RW + 1) > spd_pkg::XY_W) ? (RW + 1) : spd_pkg::XY_W;
  localparam int XE  = WCW;
  localparam int YE  = HCW;

  spd_pkg::seq_state_e state_q, state_d;
  logic [1:0]    slot_q, slot_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [7:0]    prev_q, prev_d;

  logic [CW-1:0] it_col_q;
  logic [RW-1:0] it_row_q;
  logic [7:0]    it_p_q, it_q_q, it_tdata_q;
  logic [15:0]   it_taddr_q;
  logic          it_colnz_q, it_lastcol_q, it_odd_q, it_copy_q, it_hv_q;

  logic [WCW-1:0] w_ext, w_eff;
  logic [HCW-1:0] h_ext, h_eff;
  logic           last_col, last_row, col_nz, odd_en, copy_en;
  logic [1:0]     slot_last, slot_first;
  logic           row_end, needs_credit, fire, item_done, take;
  logic [XE-1:0]  x_full;
  logic [YE-1:0]  r2;
  spd_pkg::uop_t  uop;

  assign w_ext = WCW'(cfg_i.width);
  assign h_ext = HCW'(cfg_i.height);
  assign w_eff = (w_ext == '0) ? WCW'(1) :
                 (w_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_ext;
  assign h_eff = (h_ext == '0) ? HCW'(1) :
                 (h_ext > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_ext;

  assign last_col = (WCW'(col_q) + WCW'(1)) >= w_eff;
  assign last_row = (HCW'(row_q) + HCW'(1)) >= h_eff;
  assign col_nz   = (col_q != '0);
  assign odd_en   = cfg_i.hv && (row_q != '0);
  assign copy_en  = cfg_i.hv && last_row;

  assign slot_last  = it_lastcol_q ? 2'd3 : 2'd1;
  assign slot_first = it_colnz_q ? 2'd0 : 2'd2;
  assign row_end    = (slot_q == slot_last);

  assign needs_credit = (state_q == spd_pkg::ST_ODD) || (state_q == spd_pkg::ST_EVEN) ||
                        (state_q == spd_pkg::ST_COPY);
  assign fire = (state_q != spd_pkg::ST_IDLE) && (!needs_credit || credit_ok_i);
  assign item_done = fire && ((state_q == spd_pkg::ST_WRITE) ||
                              (state_q == spd_pkg::ST_EVEN && row_end && !it_copy_q) ||
                              (state_q == spd_pkg::ST_COPY && row_end));
  assign in_ready_o = (state_q == spd_pkg::ST_IDLE) || item_done;
  assign take = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    if (take) begin
      slot_d = col_nz ? 2'd0 : 2'd2;
      priority if (in_op_i == spd_pkg::OP_WRITE) begin
        state_d = spd_pkg::ST_WRITE;
      end else if (col_nz) begin
        state_d = spd_pkg::ST_BLEND;
      end else if (!last_col) begin
        state_d = spd_pkg::ST_IDLE;
      end else if (odd_en) begin
        state_d = spd_pkg::ST_ODD;
      end else begin
        state_d = spd_pkg::ST_EVEN;
      end
    end else if (item_done) begin
      state_d = spd_pkg::ST_IDLE;
    end else if (fire) begin
      unique case (state_q)
        spd_pkg::ST_BLEND: begin
          state_d = it_odd_q ? spd_pkg::ST_ODD : spd_pkg::ST_EVEN;
        end
        spd_pkg::ST_ODD: begin
          if (row_end) begin
            state_d = spd_pkg::ST_EVEN;
            slot_d  = slot_first;
          end else begin
            slot_d = slot_q + 2'd1;
          end
        end
        spd_pkg::ST_EVEN: begin
          if (row_end) begin
            state_d = spd_pkg::ST_COPY;
            slot_d  = slot_first;
          end else begin
            slot_d = slot_q + 2'd1;
          end
        end
        spd_pkg::ST_COPY: begin
          slot_d = slot_q + 2'd1;
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  // stream counters
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    prev_d = prev_q;
    if (take && in_op_i == spd_pkg::OP_PIXEL) begin
      prev_d = in_pixel_i;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign x_full    = (XE'(it_col_q) << 1) + XE'(slot_q) - XE'(2);
  assign r2        = YE'(it_row_q) << 1;
  assign lb_addr_o = x_full[CW:0];

  // outputs
  always_comb begin
    uop = '0;
    uop.x = x_full[spd_pkg::XY_W-1:0];
    uop.use_h = (slot_q == 2'd1);
    uop.v = (slot_q == 2'd0) ? it_p_q : it_q_q;
    uop.last = (state_q == spd_pkg::ST_EVEN && row_end && !it_copy_q) ||
               (state_q == spd_pkg::ST_COPY && row_end);
    if (fire) begin
      unique case (state_q)
        spd_pkg::ST_WRITE: begin
          uop.wr    = 1'b1;
          uop.use_h = 1'b0;
          uop.taddr = it_taddr_q;
          uop.v     = it_tdata_q;
        end
        spd_pkg::ST_BLEND: begin
          uop.hb    = 1'b1;
          uop.taddr = {it_p_q, it_q_q};
        end
        spd_pkg::ST_ODD: begin
          uop.vld = 1'b1;
          uop.odd = 1'b1;
          uop.y   = spd_pkg::XY_W'(r2 - YE'(1));
        end
        spd_pkg::ST_EVEN: begin
          uop.vld = 1'b1;
          uop.lbw = it_hv_q;
          uop.y   = it_hv_q ? spd_pkg::XY_W'(r2) : spd_pkg::XY_W'(it_row_q);
        end
        spd_pkg::ST_COPY: begin
          uop.vld = 1'b1;
          uop.y   = spd_pkg::XY_W'(r2 + YE'(1));
        end
        default: begin
          uop.vld = 1'b0;
        end
      endcase
    end
  end

  assign uop_o = uop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spd_pkg::ST_IDLE;
      slot_q  <= 2'd0;
      col_q   <= '0;
      row_q   <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      col_q   <= col_d;
      row_q   <= row_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      it_col_q     <= col_q;
      it_row_q     <= row_q;
      it_p_q       <= prev_q;
      it_q_q       <= in_pixel_i;
      it_colnz_q   <= col_nz;
      it_lastcol_q <= last_col;
      it_odd_q     <= odd_en;
      it_copy_q    <= copy_en;
      it_hv_q      <= cfg_i.hv;
      it_taddr_q   <= in_tidx_i;
      it_tdata_q   <= in_tdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/spd_pipe.sv =====
`default_nettype none
module spd_pipe #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  spd_pkg::uop_t              uop_i,
  input  wire  [$clog2(MAX_WIDTH):0] lb_addr_i,
  output logic                       res_valid_o,
  output spd_pkg::res_t              res_o,
  output logic [1:0]                 inflight_o
);

  localparam int LB_DEPTH = 2 * MAX_WIDTH;

  logic [7:0] tbl_mem [spd_pkg::TBL_DEPTH];
  logic [7:0] lb_mem  [LB_DEPTH];

  logic [7:0]  h_q, v_a, lb_rd_q, tbl_rd_q;
  logic        tbl_re;
  logic [15:0] tbl_raddr;

  logic                     b_vld_q, b_hb_q, b_odd_q, b_last_q;
  logic [spd_pkg::XY_W-1:0] b_x_q, b_y_q;
  logic [7:0]               b_v_q;
  logic                     c_vld_q, c_odd_q, c_last_q;
  logic [spd_pkg::XY_W-1:0] c_x_q, c_y_q;
  logic [7:0]               c_v_q;

  assign v_a       = uop_i.use_h ? h_q : uop_i.v;
  assign tbl_re    = uop_i.hb || (b_vld_q && b_odd_q);
  assign tbl_raddr = uop_i.hb ? uop_i.taddr : {b_v_q, lb_rd_q};

  always_ff @(posedge clk_i) begin
    if (uop_i.wr) begin
      tbl_mem[uop_i.taddr] <= uop_i.v;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (uop_i.vld && uop_i.lbw) begin
      lb_mem[lb_addr_i] <= v_a;
    end
    if (uop_i.vld && uop_i.odd) begin
      lb_rd_q <= lb_mem[lb_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      b_hb_q  <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      b_vld_q <= uop_i.vld;
      b_hb_q  <= uop_i.hb;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_hb_q) begin
      h_q <= tbl_rd_q;
    end
    b_odd_q  <= uop_i.odd;
    b_last_q <= uop_i.last;
    b_x_q    <= uop_i.x;
    b_y_q    <= uop_i.y;
    b_v_q    <= v_a;
    c_odd_q  <= b_odd_q;
    c_last_q <= b_last_q;
    c_x_q    <= b_x_q;
    c_y_q    <= b_y_q;
    c_v_q    <= b_v_q;
  end

  assign res_valid_o = c_vld_q;
  assign res_o.last  = c_last_q;
  assign res_o.pix   = c_odd_q ? tbl_rd_q : c_v_q;
  assign res_o.y     = c_y_q;
  assign res_o.x     = c_x_q;
  assign inflight_o  = {1'b0, b_vld_q} + {1'b0, c_vld_q};

endmodule
`default_nettype wire

// ===== sv/spd_outq.sv =====
`default_nettype none
module spd_outq (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           push_i,
  input  spd_pkg::res_t                 push_data_i,
  output logic                          valid_o,
  input  wire                           ready_i,
  output spd_pkg::res_t                 data_o,
  output logic [spd_pkg::OQ_AW:0]       count_o
);

  spd_pkg::res_t               ent_q [spd_pkg::OQ_DEPTH];
  logic [spd_pkg::OQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [spd_pkg::OQ_AW:0]     cnt_q, cnt_d;
  logic                        pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = ent_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + (spd_pkg::OQ_AW + 1)'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - (spd_pkg::OQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + spd_pkg::OQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + spd_pkg::OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/smooth_pixel_doubler.sv =====
// 2x palette image upscaler with blend-table smoothing.
// Input stream (s_axis): tuser = 0 carries a source pixel in raster order,
// tuser = 1 writes one byte of the 64K blend table. Load the table before
// any pixel that reads it. Output stream (m_axis): one transfer per output
// pixel with its x,y in the doubled image; tlast marks the final output
// caused by one input transfer. Pixels that complete no column give none.
// Config port: width, height and mode; the user must write them only while
// the block is idle, the block itself does not enforce it. A table write is
// one operation. A pixel issues a blend lookup when it completes a pair, plus
// one operation per output pixel (2 or 4 per row emitted, up to 3 rows in hv
// mode): the sequencer issues one operation per cycle through the single
// table read port, row operations waiting for output queue credit. Each output
// passes the registered sequencer state, pipeline registers b and c and the
// output queue. The next input is taken in the cycle the previous item
// issues its last operation. Receiver stall: a 4-entry output queue with
// credit check holds results; the sequencer pauses, input backs up through s_axis_tready.
// Reset: counters and previous pixel clear, width = height = 1, mode 0.
// Table and line buffer contents are not cleared; no clearing pass.
`default_nettype none
module smooth_pixel_doubler #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // pixel[7:0], table_index[23:8], table_data[31:24]
  input  wire         s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_x[10:0], out_y[21:11], out_pixel[29:22], zero
  output logic        m_axis_tlast,
  input  wire                               cfg_we_i,
  input  wire  [spd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [spd_pkg::XY_W-1:0]          cfg_data_i
);

  spd_pkg::cfg_t                 cfg_q;
  spd_pkg::uop_t                 a_uop;
  logic [$clog2(MAX_WIDTH):0]    lb_addr;
  logic                          res_valid;
  spd_pkg::res_t                 res, q_data;
  logic [1:0]                    inflight;
  logic [spd_pkg::OQ_AW:0]       oq_cnt;
  logic                          credit_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= spd_pkg::XY_W'(1);
      cfg_q.height <= spd_pkg::XY_W'(1);
      cfg_q.hv     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spd_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data_i;
        spd_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data_i;
        spd_pkg::CFG_MODE:   cfg_q.hv     <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign credit_ok = ((spd_pkg::OQ_AW + 1)'(oq_cnt) + (spd_pkg::OQ_AW + 1)'(inflight)) <
                     (spd_pkg::OQ_AW + 1)'(spd_pkg::OQ_DEPTH);

  spd_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_pixel_i  (s_axis_tdata[7:0]),
    .in_tidx_i   (s_axis_tdata[23:8]),
    .in_tdata_i  (s_axis_tdata[31:24]),
    .credit_ok_i (credit_ok),
    .uop_o       (a_uop),
    .lb_addr_o   (lb_addr)
  );

  spd_pipe #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_i       (a_uop),
    .lb_addr_i   (lb_addr),
    .res_valid_o (res_valid),
    .res_o       (res),
    .inflight_o  (inflight)
  );

  spd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (q_data),
    .count_o     (oq_cnt)
  );

  assign m_axis_tdata = {2'b00, q_data.pix, q_data.y, q_data.x};
  assign m_axis_tlast = q_data.last;

`ifndef ASSERT_OFF
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((spd_pkg::OQ_AW + 1)'(oq_cnt) + (spd_pkg::OQ_AW + 1)'(inflight)) <=
    (spd_pkg::OQ_AW + 1)'(spd_pkg::OQ_DEPTH))
    else $error("output queue credit exceeded");

  a_write_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> a_uop.wr)
    else $error("table write not issued after its transfer");

  a_blend_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_uop.hb |=> !a_uop.hb && !a_uop.wr)
    else $error("blend lookup not followed by a row operation");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({a_uop.vld, a_uop.hb, a_uop.wr}))
    else $error("more than one operation issued in a cycle");
`endif

endmodule
`default_nettype wire
